// ----- rtl/tmprof_pkg.sv -----
`timescale 1ns / 1ps
// tmprof_pkg.sv: types, codes, widths and helpers for the trapezoidal motion profiler
// no dependencies; used by the channel interfaces and the profiler core

package tmprof_pkg;

  // default channel widths
  localparam int ODO_BITS_DEF = 24;
  localparam int VEL_BITS_DEF = 14;

  // fixed field widths
  localparam int ACCEL_W    = 16;
  localparam int VCMD_W     = 13;
  localparam int DIST_W     = 16;
  localparam int ACMD_W     = 17;
  localparam int PHASE_W    = 2;
  localparam int BOUND_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // divisor is twice the acceleration
  localparam int DIV_W = ACCEL_W + 1;

  // peak velocity stays below 2^17 while velocities fit in 17 bits,
  // since the 2*accel*distance term is below 2^33
  localparam int PEAK_MIN_W = 17;

  // register reset values
  localparam logic [ACCEL_W-1:0] ACCEL_RST       = 16'd1000;
  localparam logic [VCMD_W-1:0]  CRUISE_VEL_RST  = 13'd500;
  localparam logic [VCMD_W-1:0]  FINAL_VEL_RST   = 13'd0;
  localparam logic [DIST_W-1:0]  TARGET_DIST_RST = 16'd180;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL       = 2'd0,
    CFG_CRUISE_VEL  = 2'd1,
    CFG_FINAL_VEL   = 2'd2,
    CFG_TARGET_DIST = 2'd3
  } cfg_idx_t;

  // item operation codes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // motion phase
  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } phase_t;

  // which ramp the shared divider works on
  typedef enum logic {
    RAMP_UP   = 1'b0,
    RAMP_DOWN = 1'b1
  } ramp_sel_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_SAMPLE   = 3'd1,
    ST_RAMP_MUL = 3'd2,
    ST_RAMP_DIV = 3'd3,
    ST_FLAT     = 3'd4,
    ST_ARG      = 3'd5,
    ST_SQRT     = 3'd6,
    ST_COMMIT   = 3'd7
  } seq_state_t;

  localparam logic signed [63:0] SAT32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT32_MIN = 64'shFFFF_FFFF_8000_0000;

  // clamp to the signed 32 bit range
  function automatic logic signed [BOUND_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [BOUND_W-1:0] r;
    if (x > SAT32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(x[BOUND_W-1:0]);
    end
    return r;
  endfunction

  // commanded acceleration for a phase
  function automatic logic signed [ACMD_W-1:0] accel_cmd_of(input phase_t ph,
                                                            input logic [ACCEL_W-1:0] a);
    logic signed [ACMD_W-1:0] pos;
    logic signed [ACMD_W-1:0] r;
    pos = $signed({1'b0, a});
    unique case (ph)
      PH_ACCEL: r = pos;
      PH_DECEL: r = -pos;
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/tmprof_if.sv -----
`timescale 1ns / 1ps
// tmprof_if.sv: valid/ready channel interfaces for profiler items and results
// depends on tmprof_pkg for widths

interface tmprof_in_if #(
  parameter int ODO_BITS = tmprof_pkg::ODO_BITS_DEF,
  parameter int VEL_BITS = tmprof_pkg::VEL_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [ODO_BITS-1:0]        odometer;
  logic signed [VEL_BITS-1:0] velocity;

  modport source (output valid, op, odometer, velocity, input ready);
  modport sink (input valid, op, odometer, velocity, output ready);
endinterface

interface tmprof_out_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [tmprof_pkg::ACMD_W-1:0]        accel_cmd;
  logic [tmprof_pkg::VCMD_W-1:0]               velocity_cmd;
  logic                                        velocity_cmd_valid;
  logic [tmprof_pkg::PHASE_W-1:0]              phase;
  logic                                        finished;

  modport source (output valid, accel_cmd, velocity_cmd, velocity_cmd_valid, phase, finished,
                  input ready);
  modport sink (input valid, accel_cmd, velocity_cmd, velocity_cmd_valid, phase, finished,
                output ready);
endinterface

// ----- rtl/trapezoidal_motion_profiler_core.sv -----
`timescale 1ns / 1ps
// trapezoidal_motion_profiler_core.sv: plans a straight move and sequences its phases
// depends on tmprof_pkg and the channel interfaces in tmprof_if.sv

// One item is in work at a time; the input is ready only while the sequencer is
// idle, and a result waits in an output register so the next item can be taken
// meanwhile. A sample item passes through the sample state, where its result is
// loaded once the output register is free. A start item is planned by one shared
// multiplier, a restoring divider that makes one quotient bit per cycle, and a
// digit-by-digit root unit that makes one root bit per cycle. With
// PW = max(17, VEL_BITS) each ramp quotient is 2*PW+2 bits. A trapezoidal plan
// multiplies and divides for each ramp, up then down, then forms the flat span
// and commits; a negative span makes it sum products, take the peak as a root
// and plan both ramps again. A stalled result register holds the sequencer.
// Boundaries are compared with the distance since start modulo 2^ODO_BITS.

module trapezoidal_motion_profiler_core #(
  parameter int ODO_BITS = tmprof_pkg::ODO_BITS_DEF,
  parameter int VEL_BITS = tmprof_pkg::VEL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  tmprof_in_if.sink                            in_ch,
  tmprof_out_if.source                         out_ch,
  input  logic                                 cfg_we,
  input  logic [tmprof_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tmprof_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ACCEL_W = tmprof_pkg::ACCEL_W;
  localparam int VCMD_W  = tmprof_pkg::VCMD_W;
  localparam int DIST_W  = tmprof_pkg::DIST_W;
  localparam int ACMD_W  = tmprof_pkg::ACMD_W;
  localparam int BOUND_W = tmprof_pkg::BOUND_W;
  localparam int DW      = tmprof_pkg::DIV_W;
  localparam int PW      = (VEL_BITS > tmprof_pkg::PEAK_MIN_W) ? VEL_BITS
                                                               : tmprof_pkg::PEAK_MIN_W;
  localparam int UW      = PW + 1;
  localparam int SW      = PW + 2;
  localparam int MAGW    = 2 * UW;
  localparam int EW      = MAGW + 2;
  localparam int CW      = $clog2(MAGW + 1);
  localparam int CMP_W   = BOUND_W + 1;

  localparam logic [CW-1:0] DIV_LAST  = CW'(MAGW - 1);
  localparam logic [CW-1:0] SQRT_LAST = CW'(PW - 1);
  localparam logic [CW-1:0] ARG_AL    = CW'(0);
  localparam logic [CW-1:0] ARG_VS    = CW'(1);
  localparam logic [CW-1:0] ARG_LAST  = CW'(3);

  // configuration registers
  logic [ACCEL_W-1:0] accel_r;
  logic [VCMD_W-1:0]  cruise_vel_r;
  logic [VCMD_W-1:0]  final_vel_r;
  logic [DIST_W-1:0]  target_dist_r;

  // sequencer and profile state
  tmprof_pkg::seq_state_t   state_r, state_nxt;
  tmprof_pkg::phase_t       phase_r;
  logic [ODO_BITS-1:0]      start_odo_r;
  logic signed [BOUND_W-1:0] ramp_up_end_r, cruise_end_r, move_end_r;

  // captured item
  logic [ODO_BITS-1:0]        odo_r;
  logic signed [VEL_BITS-1:0] vel_r;

  // planner datapath
  logic [DW-1:0]            div_r;
  logic [MAGW-1:0]          prod_r;
  logic [DW-1:0]            rem_r;
  logic                     neg_r;
  logic [CW-1:0]            cnt_r;
  tmprof_pkg::ramp_sel_t    ramp_sel_r;
  logic                     tri_r;
  logic signed [EW-1:0]     up_r, down_r, flat_r;
  logic [MAGW-1:0]          acc_r;
  logic [2*PW-1:0]          rad_r;
  logic [PW+1:0]            srem_r;
  logic [PW-1:0]            root_r;
  logic [PW-1:0]            peak_r;

  // output register
  logic                     out_valid_r;
  logic signed [ACMD_W-1:0] out_acmd_r;
  logic [VCMD_W-1:0]        out_vcmd_r;
  logic                     out_vcmd_valid_r;
  tmprof_pkg::phase_t       out_phase_r;
  logic                     out_fin_r;

  // handshake and control
  logic in_ready, in_accept, out_free, load_res;

  // combinational datapath
  logic signed [SW-1:0] vs_ext, vc_ext, ve_ext, peak_ext, rx, ry, rsum, rdiff;
  logic [SW-1:0]        rsum_mag, vs_mag;
  logic [UW-1:0]        mul_a, mul_b;
  logic [MAGW-1:0]      mul_p;
  logic [DW:0]          div_sh;
  logic                 div_ge;
  logic [DW-1:0]        div_rem_nxt;
  logic [MAGW-1:0]      q_mag;
  logic [EW-1:0]        q_ext;
  logic signed [EW-1:0] q_s;
  logic signed [EW-1:0] flat_calc, end_cruise, end_move;
  logic [MAGW-1:0]      acc_sum;
  logic [PW+1:0]        sq_sh, sq_trial, sq_rem_nxt;
  logic                 sq_ge;
  logic [ACCEL_W-1:0]   accel_eff;

  // sample checks
  logic [ODO_BITS-1:0]      travel;
  logic signed [CMP_W-1:0]  dist_ext;
  logic                     gt_up, gt_cr, gt_mv, vel_low, fin;
  tmprof_pkg::phase_t       ph1, ph2, ph3, res_phase;
  logic                     res_fin;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r       <= tmprof_pkg::ACCEL_RST;
      cruise_vel_r  <= tmprof_pkg::CRUISE_VEL_RST;
      final_vel_r   <= tmprof_pkg::FINAL_VEL_RST;
      target_dist_r <= tmprof_pkg::TARGET_DIST_RST;
    end else if (cfg_we) begin
      unique case (tmprof_pkg::cfg_idx_t'(cfg_index))
        tmprof_pkg::CFG_ACCEL:       accel_r       <= cfg_data[ACCEL_W-1:0];
        tmprof_pkg::CFG_CRUISE_VEL:  cruise_vel_r  <= cfg_data[VCMD_W-1:0];
        tmprof_pkg::CFG_FINAL_VEL:   final_vel_r   <= cfg_data[VCMD_W-1:0];
        tmprof_pkg::CFG_TARGET_DIST: target_dist_r <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // ramp operands: up is start to peak or cruise, down is peak or cruise to final
  always_comb begin
    vs_ext   = SW'(vel_r);
    vc_ext   = SW'(cruise_vel_r);
    ve_ext   = SW'(final_vel_r);
    peak_ext = SW'(peak_r);
    if (ramp_sel_r == tmprof_pkg::RAMP_UP) begin
      rx = vs_ext;
      ry = tri_r ? peak_ext : vc_ext;
    end else begin
      rx = tri_r ? peak_ext : vc_ext;
      ry = ve_ext;
    end
    rsum     = rx + ry;
    rdiff    = (rx >= ry) ? (rx - ry) : (ry - rx);
    rsum_mag = rsum[SW-1] ? SW'(-rsum) : SW'(rsum);
    vs_mag   = vs_ext[SW-1] ? SW'(-vs_ext) : SW'(vs_ext);
  end

  // shared multiplier operand select
  always_comb begin
    if (state_r == tmprof_pkg::ST_ARG) begin
      priority if (cnt_r == ARG_AL) begin
        mul_a = UW'(accel_r);
        mul_b = UW'(target_dist_r);
      end else if (cnt_r == ARG_VS) begin
        mul_a = vs_mag[UW-1:0];
        mul_b = vs_mag[UW-1:0];
      end else begin
        mul_a = UW'(final_vel_r);
        mul_b = UW'(final_vel_r);
      end
    end else begin
      mul_a = rsum_mag[UW-1:0];
      mul_b = rdiff[UW-1:0];
    end
    mul_p = mul_a * mul_b;
  end

  // restoring divider step, root step and planning sums
  always_comb begin
    accel_eff   = (accel_r == '0) ? ACCEL_W'(1) : accel_r;
    div_sh      = {rem_r, prod_r[MAGW-1]};
    div_ge      = (div_sh >= {1'b0, div_r});
    div_rem_nxt = div_ge ? DW'(div_sh - {1'b0, div_r}) : div_sh[DW-1:0];
    q_mag       = {prod_r[MAGW-2:0], div_ge};
    q_ext       = EW'(q_mag);
    q_s         = neg_r ? -$signed(q_ext) : $signed(q_ext);
    flat_calc   = $signed(EW'(target_dist_r)) - up_r - down_r;
    end_cruise  = up_r + flat_r;
    end_move    = end_cruise + down_r;
    acc_sum     = acc_r + prod_r;
    sq_sh       = {srem_r[PW-1:0], rad_r[2*PW-1 -: 2]};
    sq_trial    = {root_r, 2'b01};
    sq_ge       = (sq_sh >= sq_trial);
    sq_rem_nxt  = sq_ge ? (sq_sh - sq_trial) : sq_sh;
  end

  // boundary checks of a sample, chained through the phases
  always_comb begin
    travel   = odo_r - start_odo_r;
    dist_ext = $signed(CMP_W'(travel));
    gt_up    = dist_ext > CMP_W'(ramp_up_end_r);
    gt_cr    = dist_ext > CMP_W'(cruise_end_r);
    gt_mv    = dist_ext > CMP_W'(move_end_r);
    vel_low  = vs_ext < ve_ext;
    ph1 = (phase_r == tmprof_pkg::PH_ACCEL && gt_up) ? tmprof_pkg::PH_CRUISE : phase_r;
    ph2 = (ph1 == tmprof_pkg::PH_CRUISE && gt_cr) ? tmprof_pkg::PH_DECEL : ph1;
    fin = (ph2 == tmprof_pkg::PH_DECEL) && (gt_mv || vel_low);
    ph3 = fin ? tmprof_pkg::PH_IDLE : ph2;
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmprof_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (in_ch.op == tmprof_pkg::OP_START) ? tmprof_pkg::ST_RAMP_MUL
                                                         : tmprof_pkg::ST_SAMPLE;
        end
      end
      tmprof_pkg::ST_SAMPLE: begin
        if (out_free) state_nxt = tmprof_pkg::ST_IDLE;
      end
      tmprof_pkg::ST_RAMP_MUL: state_nxt = tmprof_pkg::ST_RAMP_DIV;
      tmprof_pkg::ST_RAMP_DIV: begin
        if (cnt_r == DIV_LAST) begin
          priority if (ramp_sel_r == tmprof_pkg::RAMP_UP) state_nxt = tmprof_pkg::ST_RAMP_MUL;
          else if (tri_r)                                 state_nxt = tmprof_pkg::ST_COMMIT;
          else                                            state_nxt = tmprof_pkg::ST_FLAT;
        end
      end
      tmprof_pkg::ST_FLAT: begin
        state_nxt = flat_calc[EW-1] ? tmprof_pkg::ST_ARG : tmprof_pkg::ST_COMMIT;
      end
      tmprof_pkg::ST_ARG: begin
        if (cnt_r == ARG_LAST) state_nxt = tmprof_pkg::ST_SQRT;
      end
      tmprof_pkg::ST_SQRT: begin
        if (cnt_r == SQRT_LAST) state_nxt = tmprof_pkg::ST_RAMP_MUL;
      end
      tmprof_pkg::ST_COMMIT: begin
        if (out_free) state_nxt = tmprof_pkg::ST_IDLE;
      end
      default: state_nxt = tmprof_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = (state_r == tmprof_pkg::ST_IDLE);
    in_accept = in_ch.valid && in_ready;
    out_free  = !out_valid_r || out_ch.ready;
    load_res  = out_free && (state_r == tmprof_pkg::ST_SAMPLE ||
                             state_r == tmprof_pkg::ST_COMMIT);
    res_fin   = (state_r == tmprof_pkg::ST_SAMPLE) && fin;
    res_phase = (state_r == tmprof_pkg::ST_COMMIT) ? tmprof_pkg::PH_ACCEL : ph3;
  end

  // control and profile state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tmprof_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      phase_r       <= tmprof_pkg::PH_IDLE;
      start_odo_r   <= '0;
      ramp_up_end_r <= '0;
      cruise_end_r  <= '0;
      move_end_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (load_res) begin
        phase_r <= res_phase;
      end
      if (load_res && state_r == tmprof_pkg::ST_COMMIT) begin
        start_odo_r   <= odo_r;
        ramp_up_end_r <= tmprof_pkg::sat32(64'(up_r));
        cruise_end_r  <= tmprof_pkg::sat32(64'(end_cruise));
        move_end_r    <= tmprof_pkg::sat32(64'(end_move));
      end
    end
  end

  // planner datapath: ramp and radicand multiplies, then divide or root iterations
  always_ff @(posedge clk) begin
    if (in_accept) begin
      odo_r      <= in_ch.odometer;
      vel_r      <= in_ch.velocity;
      div_r      <= {accel_eff, 1'b0};
      ramp_sel_r <= tmprof_pkg::RAMP_UP;
      tri_r      <= 1'b0;
      flat_r     <= '0;
    end
    unique case (state_r)
      tmprof_pkg::ST_RAMP_MUL: begin
        prod_r <= mul_p;
        neg_r  <= rsum[SW-1];
        rem_r  <= '0;
        cnt_r  <= '0;
      end
      tmprof_pkg::ST_RAMP_DIV: begin
        prod_r <= q_mag;
        rem_r  <= div_rem_nxt;
        cnt_r  <= cnt_r + CW'(1);
        if (cnt_r == DIV_LAST) begin
          if (ramp_sel_r == tmprof_pkg::RAMP_UP) begin
            up_r       <= q_s;
            ramp_sel_r <= tmprof_pkg::RAMP_DOWN;
          end else begin
            down_r <= q_s;
          end
        end
      end
      tmprof_pkg::ST_FLAT: begin
        cnt_r <= '0;
        if (flat_calc[EW-1]) begin
          tri_r <= 1'b1;
        end else begin
          flat_r <= flat_calc;
        end
      end
      tmprof_pkg::ST_ARG: begin
        // 2*accel*distance + vs^2 + ve^2, one product per cycle
        prod_r <= mul_p;
        cnt_r  <= (cnt_r == ARG_LAST) ? '0 : cnt_r + CW'(1);
        priority if (cnt_r == ARG_AL) acc_r <= '0;
        else if (cnt_r == ARG_VS)     acc_r <= {prod_r[MAGW-2:0], 1'b0};
        else                          acc_r <= acc_sum;
        if (cnt_r == ARG_LAST) begin
          rad_r  <= acc_sum[2*PW:1];
          srem_r <= '0;
          root_r <= '0;
        end
      end
      tmprof_pkg::ST_SQRT: begin
        srem_r <= sq_rem_nxt;
        root_r <= {root_r[PW-2:0], sq_ge};
        rad_r  <= {rad_r[2*PW-3:0], 2'b00};
        cnt_r  <= cnt_r + CW'(1);
        if (cnt_r == SQRT_LAST) begin
          peak_r     <= {root_r[PW-2:0], sq_ge};
          ramp_sel_r <= tmprof_pkg::RAMP_UP;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_res) begin
      out_acmd_r       <= tmprof_pkg::accel_cmd_of(res_phase, accel_r);
      out_vcmd_r       <= res_fin ? final_vel_r : '0;
      out_vcmd_valid_r <= res_fin;
      out_phase_r      <= res_phase;
      out_fin_r        <= res_fin;
    end
  end

  // channel wiring
  assign in_ch.ready               = in_ready;
  assign out_ch.valid              = out_valid_r;
  assign out_ch.accel_cmd          = out_acmd_r;
  assign out_ch.velocity_cmd       = out_vcmd_r;
  assign out_ch.velocity_cmd_valid = out_vcmd_valid_r;
  assign out_ch.phase              = out_phase_r;
  assign out_ch.finished           = out_fin_r;

  // a finishing result is idle, issues the velocity and commands no acceleration
  a_fin_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fin_r) |->
      (out_phase_r == tmprof_pkg::PH_IDLE && out_vcmd_valid_r && out_acmd_r == '0))
    else $error("finishing result with inconsistent fields");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmprof_pkg::ST_RAMP_DIV) |-> (rem_r < div_r))
    else $error("divider remainder out of range");

  // root remainder never exceeds twice the partial root
  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmprof_pkg::ST_SQRT) |-> (srem_r <= (PW+2)'({root_r, 1'b0})))
    else $error("root remainder out of range");

  // a committed plan starts the accelerate phase with a result shown
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmprof_pkg::ST_COMMIT && load_res) |=>
      (phase_r == tmprof_pkg::PH_ACCEL && out_valid_r))
    else $error("plan commit did not start the move");

  // no second item is taken while one is in work
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_ready)
    else $error("item accepted while busy");

endmodule
